@@ rtl/zcdl_pkg.sv @@
// ----------------------------------------------------------------------------
// zcdl_pkg
// Types and constants shared by the central directory lister.
// ----------------------------------------------------------------------------
package zcdl_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME      = 2'd0,
    KIND_NOT_FOUND = 2'd1,
    KIND_MALFORMED = 2'd2,
    KIND_FINISHED  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  name_byte;
    logic        name_end;
    logic [15:0] entry_number;
  } res_t;

  localparam logic [31:0] SIG_WORD    = 32'h504B_0102;
  localparam logic [5:0]  FIXED_LAST  = 6'd45;  // last byte of fixed header
  localparam logic [5:0]  OFS_NAME    = 6'd28;
  localparam logic [5:0]  OFS_EXTRA   = 6'd30;
  localparam logic [5:0]  OFS_COMMENT = 6'd32;
  localparam logic [5:0]  SIG_LEN     = 6'd4;
  localparam logic [18:0] FIXED_TAIL  = 19'd12; // header bytes after offset 33
  localparam logic [15:0] IDX_MAX     = 16'hFFFF;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = SIG_WORD[31:24];
      2'd1:    r = SIG_WORD[23:16];
      2'd2:    r = SIG_WORD[15:8];
      default: r = SIG_WORD[7:0];
    endcase
    return r;
  endfunction

endpackage

@@ rtl/zip_central_directory_lister.sv @@
// A result word enters the result queue when the byte that causes it is
// accepted. Bytes go in at one per cycle unless stalled; a byte causing two
// words (a name byte plus a terminal word) takes two result queue slots.
// The byte port stalls only while the four-entry result queue has under two
// free slots. Reset clears the walk state, the queue and the length register;
// a byte marked last returns the walk state to reset and keeps the length.
// ----------------------------------------------------------------------------
// zip_central_directory_lister
// Walks the central directory of an archive byte stream and lists names.
// ----------------------------------------------------------------------------
module zip_central_directory_lister #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_archive_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_byte_o,
  output logic        name_end_o,
  output logic [15:0] entry_number_o
);

  localparam int EXT_W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

  // walk state
  logic [31:0]              len_q;
  logic [31:0]              mw_q, mw_d;
  zcdl_pkg::phase_e         ph_q, ph_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [5:0]               rbc_q, rbc_d;
  logic [15:0]              name_q, name_d;
  logic [15:0]              extra_q, extra_d;
  logic [7:0]               clo_q, clo_d;
  logic [17:0]              sum_q, sum_d;
  logic [16:0]              tail_q, tail_d;
  logic [17:0]              skip_q, skip_d;
  logic [15:0]              idx_q, idx_d;

  // result queue
  zcdl_pkg::res_t rq_q [4];
  logic [1:0]     wr_ptr_q, rd_ptr_q;
  logic [2:0]     cnt_q;

  logic           in_acc, out_acc;
  zcdl_pkg::res_t r0, r1;
  logic [1:0]     n_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q > 3'd2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;

  // position against archive length
  logic [EXT_W-1:0] pos_ext, len_ext, diff;
  logic             at_end;
  logic [31:0]      left;
  assign pos_ext = EXT_W'(pos_q);
  assign len_ext = EXT_W'(len_q);
  assign diff    = len_ext - pos_ext;
  assign at_end  = (pos_ext >= len_ext) || (diff == EXT_W'(1));
  assign left    = at_end ? 32'd0 : 32'(diff - EXT_W'(1));

  // per-byte step
  always_comb begin
    logic        term;
    logic        boundary;
    logic [7:0]  b;
    logic [15:0] cfull;
    logic [17:0] sum33;
    logic [18:0] need;
    zcdl_pkg::res_t put;
    b     = data_byte_i;
    term  = 1'b0;
    boundary = 1'b0;
    cfull = {b, clo_q};
    sum33 = 18'(name_q) + 18'(extra_q) + 18'(cfull);
    need  = 19'(sum33) + zcdl_pkg::FIXED_TAIL;
    mw_d  = mw_q;
    ph_d  = ph_q;
    rbc_d = rbc_q;
    name_d  = name_q;
    extra_d = extra_q;
    clo_d   = clo_q;
    sum_d   = sum_q;
    tail_d  = tail_q;
    skip_d  = skip_q;
    idx_d   = idx_q;
    n_res   = 2'd0;
    r0      = '0;
    r1      = '0;
    put     = '0;

    case (ph_q)
      zcdl_pkg::PH_HUNT: begin
        mw_d = {mw_q[23:0], b};
        if (mw_d == zcdl_pkg::SIG_WORD) begin
          idx_d = '0;
          if (at_end) begin
            term = 1'b1;
            ph_d = zcdl_pkg::PH_DONE;
          end else begin
            ph_d  = zcdl_pkg::PH_HEAD;
            rbc_d = zcdl_pkg::SIG_LEN;
          end
        end else if (at_end) begin
          term = 1'b1;
          ph_d = zcdl_pkg::PH_DONE;
        end
        if (term) begin
          put.kind = (mw_d == zcdl_pkg::SIG_WORD) ? zcdl_pkg::KIND_FINISHED
                                                   : zcdl_pkg::KIND_NOT_FOUND;
          put.entry_number = idx_d;
          r0    = put;
          n_res = 2'd1;
        end
      end
      zcdl_pkg::PH_HEAD: begin
        if (rbc_q < zcdl_pkg::SIG_LEN && b != zcdl_pkg::sig_byte(rbc_q[1:0])) begin
          term = 1'b1;
          ph_d = zcdl_pkg::PH_DONE;
          put.kind = zcdl_pkg::KIND_FINISHED;
          put.entry_number = idx_q;
          r0    = put;
          n_res = 2'd1;
        end else begin
          if (rbc_q == zcdl_pkg::OFS_NAME)          name_d  = {8'd0, b};
          if (rbc_q == zcdl_pkg::OFS_NAME + 6'd1)   name_d  = {b, name_q[7:0]};
          if (rbc_q == zcdl_pkg::OFS_EXTRA)         extra_d = {8'd0, b};
          if (rbc_q == zcdl_pkg::OFS_EXTRA + 6'd1)  extra_d = {b, extra_q[7:0]};
          if (rbc_q == zcdl_pkg::OFS_COMMENT)       clo_d   = b;
          if (rbc_q == zcdl_pkg::OFS_COMMENT + 6'd1) begin
            sum_d  = sum33;
            tail_d = 17'(extra_q) + 17'(cfull);
            // record must fit in what is left of the archive
            if ({14'd0, need} > {1'b0, left}) begin
              term = 1'b1;
              ph_d = zcdl_pkg::PH_DONE;
              put.kind = zcdl_pkg::KIND_MALFORMED;
              put.entry_number = idx_q;
              r0    = put;
              n_res = 2'd1;
            end
          end
          if (!term) begin
            if (rbc_q >= zcdl_pkg::FIXED_LAST) begin
              skip_d = sum_q;
              if (sum_q == '0) boundary = 1'b1;
              else             ph_d = zcdl_pkg::PH_BODY;
            end else begin
              rbc_d = rbc_q + 6'd1;
            end
          end
        end
      end
      zcdl_pkg::PH_BODY: begin
        if (skip_q > 18'(tail_q)) begin
          put.kind         = zcdl_pkg::KIND_NAME;
          put.name_byte    = b;
          put.name_end     = (skip_q == 18'(tail_q) + 18'd1);
          put.entry_number = idx_q;
          r0    = put;
          n_res = 2'd1;
        end
        if (skip_q != '0) skip_d = skip_q - 18'd1;
        if (skip_d == '0) boundary = 1'b1;
      end
      default: ;
    endcase

    if (boundary) begin
      if (idx_q != zcdl_pkg::IDX_MAX) idx_d = idx_q + 16'd1;
      if (left <= 32'd4) begin
        term = 1'b1;
        ph_d = zcdl_pkg::PH_DONE;
        put  = '0;
        put.kind = zcdl_pkg::KIND_FINISHED;
        put.entry_number = idx_d;
        if (n_res == 2'd0) r0 = put;
        else               r1 = put;
        n_res = n_res + 2'd1;
      end else begin
        ph_d  = zcdl_pkg::PH_HEAD;
        rbc_d = '0;
      end
    end

    // archive ends inside a record
    if (!term && (ph_d == zcdl_pkg::PH_HEAD || ph_d == zcdl_pkg::PH_BODY) && at_end) begin
      term = 1'b1;
      ph_d = zcdl_pkg::PH_DONE;
      put  = '0;
      put.kind = zcdl_pkg::KIND_MALFORMED;
      put.entry_number = idx_d;
      if (n_res == 2'd0) r0 = put;
      else               r1 = put;
      n_res = n_res + 2'd1;
    end

    // stream ends before any terminal word
    if (last_byte_i && !term && ph_d != zcdl_pkg::PH_DONE) begin
      put = '0;
      put.kind = (ph_d == zcdl_pkg::PH_HUNT) ? zcdl_pkg::KIND_NOT_FOUND
                                             : zcdl_pkg::KIND_MALFORMED;
      put.entry_number = idx_d;
      if (n_res == 2'd0) r0 = put;
      else               r1 = put;
      n_res = n_res + 2'd1;
    end

    pos_d = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);

    if (last_byte_i) begin
      mw_d    = '0;
      ph_d    = zcdl_pkg::PH_HUNT;
      pos_d   = '0;
      rbc_d   = '0;
      name_d  = '0;
      extra_d = '0;
      clo_d   = '0;
      sum_d   = '0;
      tail_d  = '0;
      skip_d  = '0;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      mw_q    <= '0;
      ph_q    <= zcdl_pkg::PH_HUNT;
      pos_q   <= '0;
      rbc_q   <= '0;
      name_q  <= '0;
      extra_q <= '0;
      clo_q   <= '0;
      sum_q   <= '0;
      tail_q  <= '0;
      skip_q  <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) len_q <= cfg_archive_length_i;
      if (in_acc) begin
        mw_q    <= mw_d;
        ph_q    <= ph_d;
        pos_q   <= pos_d;
        rbc_q   <= rbc_d;
        name_q  <= name_d;
        extra_q <= extra_d;
        clo_q   <= clo_d;
        sum_q   <= sum_d;
        tail_q  <= tail_d;
        skip_q  <= skip_d;
        idx_q   <= idx_d;
      end
    end
  end

  // result queue pointers
  logic [1:0] push_n;
  assign push_n = in_acc ? n_res : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (out_acc) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_n) - (out_acc ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) rq_q[wr_ptr_q] <= r0;
    if (push_n == 2'd2) rq_q[wr_ptr_q + 2'd1] <= r1;
  end

  assign kind_o         = rq_q[rd_ptr_q].kind;
  assign name_byte_o    = rq_q[rd_ptr_q].name_byte;
  assign name_end_o     = rq_q[rd_ptr_q].name_end;
  assign entry_number_o = rq_q[rd_ptr_q].entry_number;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> ph_q == zcdl_pkg::PH_HUNT && pos_q == '0)
    else $error("walk not rearmed after last byte");

  a_end_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_end_o |-> kind_o == zcdl_pkg::KIND_NAME)
    else $error("name end mark on non-name word");

  a_body_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == zcdl_pkg::PH_BODY |-> skip_q != '0)
    else $error("body phase with nothing to skip");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == zcdl_pkg::PH_HEAD |-> rbc_q <= zcdl_pkg::FIXED_LAST)
    else $error("header byte count out of range");

endmodule

@@ sim/tb_zip_central_directory_lister.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zip_central_directory_lister
// Streams archive images into the lister and predicts every result word
// (name bytes and terminal words) alongside it. Short hand-built streams hit
// the length edge cases; then random archives with real directory records,
// broken records, truncation and odd lengths. Both sides idle at random, and
// one phase parks the receiver long enough to back up the byte port.
// ----------------------------------------------------------------------------
module tb_zip_central_directory_lister;

  localparam int POS_BITS      = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int FLOOD_CYCLES  = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_BYTES  = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  logic        clk_i;
  logic        rst_ni               = 1'b0;
  logic        cfg_valid_i          = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_archive_length_i = '0;
  logic        in_valid_i           = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i          = '0;
  logic        last_byte_i          = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i          = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  name_byte_o;
  logic        name_end_o;
  logic [15:0] entry_number_o;

  zip_central_directory_lister #(
    .POSITION_BITS(POS_BITS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_archive_length_i(cfg_archive_length_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .name_byte_o         (name_byte_o),
    .name_end_o          (name_end_o),
    .entry_number_o      (entry_number_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // shared bookkeeping
  byte_word_t      archive_bytes_q[$];
  zcdl_pkg::res_t  listing_due[$];
  logic [7:0]  arc[$];
  int          bytes_sent      = 0;
  int          bytes_taken     = 0;
  int          words_predicted = 0;
  int          words_checked   = 0;
  int          mismatches      = 0;
  int          quiet_cycles    = 0;
  int          archives_run    = 0;
  int          length_writes   = 0;
  int          kind_seen[4]    = '{0, 0, 0, 0};
  bit          calm_tx         = 1'b0;
  bit          calm_rx         = 1'b0;
  bit          flood_req       = 1'b0;

  // predicted walk state
  logic [31:0]      walk_len    = '0;
  logic [31:0]      walk_window = '0;
  zcdl_pkg::phase_e walk_phase  = zcdl_pkg::PH_HUNT;
  logic [63:0] walk_pos    = '0;
  logic [5:0]  walk_cnt    = '0;
  logic [15:0] walk_nlen   = '0;
  logic [15:0] walk_xlen   = '0;
  logic [15:0] walk_clen   = '0;
  logic [17:0] walk_skip   = '0;
  logic [15:0] walk_index  = '0;

  function automatic void clear_walk();
    walk_window = '0;
    walk_phase  = zcdl_pkg::PH_HUNT;
    walk_pos    = '0;
    walk_cnt    = '0;
    walk_nlen   = '0;
    walk_xlen   = '0;
    walk_clen   = '0;
    walk_skip   = '0;
    walk_index  = '0;
  endfunction

  function automatic void emit_word(input zcdl_pkg::kind_e k, input logic [7:0] nb,
                                    input logic e);
    zcdl_pkg::res_t r;
    r.kind         = k;
    r.name_byte    = nb;
    r.name_end     = e;
    r.entry_number = walk_index;
    listing_due.push_back(r);
    words_predicted++;
  endfunction

  // one archive byte through the directory walk
  function automatic void list_step(input logic [7:0] b, input logic last);
    logic [63:0] len;
    logic [63:0] left;
    logic [63:0] need;
    logic [63:0] pos_top;
    logic [17:0] tail;
    logic        at_end;
    logic        term;
    logic        boundary;
    int          c;
    len      = {32'd0, walk_len};
    pos_top  = (64'd1 << POS_BITS) - 64'd1;
    at_end   = (walk_pos >= len) || (len - walk_pos == 64'd1);
    left     = at_end ? 64'd0 : len - walk_pos - 64'd1;
    term     = 1'b0;
    boundary = 1'b0;
    case (walk_phase)
      zcdl_pkg::PH_HUNT: begin
        walk_window = {walk_window[23:0], b};
        if (walk_window == zcdl_pkg::SIG_WORD) begin
          walk_index = '0;
          if (at_end) begin
            emit_word(zcdl_pkg::KIND_FINISHED, 8'd0, 1'b0);
            term = 1'b1;
            walk_phase = zcdl_pkg::PH_DONE;
          end else begin
            walk_phase = zcdl_pkg::PH_HEAD;
            walk_cnt = zcdl_pkg::SIG_LEN;
          end
        end else if (at_end) begin
          emit_word(zcdl_pkg::KIND_NOT_FOUND, 8'd0, 1'b0);
          term = 1'b1;
          walk_phase = zcdl_pkg::PH_DONE;
        end
      end
      zcdl_pkg::PH_HEAD: begin
        c = int'(walk_cnt);
        if (c < int'(zcdl_pkg::SIG_LEN) && b != zcdl_pkg::SIG_WORD[8 * (3 - c) +: 8]) begin
          // no signature where the next record should start: clean stop
          emit_word(zcdl_pkg::KIND_FINISHED, 8'd0, 1'b0);
          term = 1'b1;
          walk_phase = zcdl_pkg::PH_DONE;
        end else begin
          if (c == int'(zcdl_pkg::OFS_NAME))        walk_nlen[7:0]  = b;
          if (c == int'(zcdl_pkg::OFS_NAME) + 1)    walk_nlen[15:8] = b;
          if (c == int'(zcdl_pkg::OFS_EXTRA))       walk_xlen[7:0]  = b;
          if (c == int'(zcdl_pkg::OFS_EXTRA) + 1)   walk_xlen[15:8] = b;
          if (c == int'(zcdl_pkg::OFS_COMMENT))     walk_clen[7:0]  = b;
          if (c == int'(zcdl_pkg::OFS_COMMENT) + 1) begin
            walk_clen[15:8] = b;
            need = 64'(zcdl_pkg::FIXED_TAIL) + 64'(walk_nlen) + 64'(walk_xlen)
                 + 64'(walk_clen);
            if (need > left) begin
              emit_word(zcdl_pkg::KIND_MALFORMED, 8'd0, 1'b0);
              term = 1'b1;
              walk_phase = zcdl_pkg::PH_DONE;
            end
          end
          if (!term) begin
            if (c >= int'(zcdl_pkg::FIXED_LAST)) begin
              walk_skip = 18'(walk_nlen) + 18'(walk_xlen) + 18'(walk_clen);
              if (walk_skip == '0) boundary = 1'b1;
              else walk_phase = zcdl_pkg::PH_BODY;
            end else begin
              walk_cnt = walk_cnt + 6'd1;
            end
          end
        end
      end
      zcdl_pkg::PH_BODY: begin
        tail = 18'(walk_xlen) + 18'(walk_clen);
        if (walk_skip > tail) begin
          emit_word(zcdl_pkg::KIND_NAME, b, walk_skip == tail + 18'd1);
        end
        if (walk_skip != '0) walk_skip = walk_skip - 18'd1;
        if (walk_skip == '0) boundary = 1'b1;
      end
      default: ;
    endcase
    if (boundary) begin
      if (walk_index != zcdl_pkg::IDX_MAX) walk_index = walk_index + 16'd1;
      if (left <= 64'd4) begin
        emit_word(zcdl_pkg::KIND_FINISHED, 8'd0, 1'b0);
        term = 1'b1;
        walk_phase = zcdl_pkg::PH_DONE;
      end else begin
        walk_phase = zcdl_pkg::PH_HEAD;
        walk_cnt = '0;
      end
    end
    // archive ran out inside a record
    if (!term && (walk_phase == zcdl_pkg::PH_HEAD || walk_phase == zcdl_pkg::PH_BODY)
        && at_end) begin
      emit_word(zcdl_pkg::KIND_MALFORMED, 8'd0, 1'b0);
      term = 1'b1;
      walk_phase = zcdl_pkg::PH_DONE;
    end
    if (last && !term && walk_phase != zcdl_pkg::PH_DONE) begin
      emit_word(walk_phase == zcdl_pkg::PH_HUNT ? zcdl_pkg::KIND_NOT_FOUND
                                                : zcdl_pkg::KIND_MALFORMED, 8'd0, 1'b0);
    end
    if (walk_pos < pos_top) walk_pos = walk_pos + 64'd1;
    if (last) clear_walk();
  endfunction

  task automatic check_listing_word();
    zcdl_pkg::res_t w;
    if (listing_due.size() == 0) begin
      $error("unexpected word: kind %0d name_byte %0h entry %0d",
             kind_o, name_byte_o, entry_number_o);
      mismatches++;
    end else begin
      w = listing_due.pop_front();
      if (kind_o !== w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, kind_o);
        mismatches++;
      end
      if (name_byte_o !== w.name_byte) begin
        $error("name_byte: expected %0h, got %0h", w.name_byte, name_byte_o);
        mismatches++;
      end
      if (name_end_o !== w.name_end) begin
        $error("name_end: expected %0d, got %0d", w.name_end, name_end_o);
        mismatches++;
      end
      if (entry_number_o !== w.entry_number) begin
        $error("entry_number: expected %0d, got %0d", w.entry_number, entry_number_o);
        mismatches++;
      end
    end
    words_checked++;
    kind_seen[kind_o]++;
  endtask

  // monitor and watchdog
  always @(posedge clk_i) begin : monitor
    bit busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        check_listing_word();
      end
      if (in_valid_i && !in_stall_o) begin
        busy = 1'b1;
        list_step(data_byte_i, last_byte_i);
        bytes_taken++;
      end
      if (cfg_valid_i && cfg_ready_o) busy = 1'b1;
      if (busy) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("watchdog: nothing moved for %0d cycles, %0d words outstanding",
                   quiet_cycles, listing_due.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_tx || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // byte driver
  int         tx_gap = 0;
  byte_word_t tx_next;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
      last_byte_i <= 1'b0;
      tx_gap      <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (tx_gap != 0) begin
        tx_gap     <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (archive_bytes_q.size() != 0) begin
        tx_next     = archive_bytes_q.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= tx_next.data;
        last_byte_i <= tx_next.last;
        tx_gap      <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver
  int rx_hold = 0;
  int rx_roll;
  bit flood_seen = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_hold     <= 0;
      flood_seen  <= 1'b0;
    end else if (flood_req && !flood_seen) begin
      // park the receiver so the result queue fills and the byte port backs up
      flood_seen  <= 1'b1;
      rx_hold     <= FLOOD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (calm_rx) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 55) begin
        out_stall_i <= 1'b0;
        rx_hold     <= $urandom_range(0, 4);
      end else if (rx_roll < 88) begin
        out_stall_i <= 1'b1;
        rx_hold     <= $urandom_range(0, 3);
      end else begin
        out_stall_i <= 1'b1;
        rx_hold     <= $urandom_range(8, 40);
      end
    end
  end

  task automatic wait_settled();
    do @(posedge clk_i);
    while (bytes_taken != bytes_sent || listing_due.size() != 0);
  endtask

  task automatic write_length(input logic [31:0] len_v);
    @(posedge clk_i);
    cfg_valid_i          <= 1'b1;
    cfg_archive_length_i <= len_v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    walk_len = len_v;
    length_writes++;
  endtask

  // settle, set the length, then stream arc with last on its final word
  task automatic run_stream(input logic [31:0] len_v, input bit split);
    byte_word_t w;
    wait_settled();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_length(len_v);
    foreach (arc[i]) begin
      if (split && i == arc.size() / 2) wait_settled();
      w.data = arc[i];
      w.last = (i == arc.size() - 1);
      archive_bytes_q.push_back(w);
      bytes_sent++;
    end
    archives_run++;
  endtask

  task automatic add_random(input int n);
    repeat (n) arc.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_record(input int nl, input int xl, input int cl, input bit with_body);
    arc.push_back(zcdl_pkg::SIG_WORD[31:24]);
    arc.push_back(zcdl_pkg::SIG_WORD[23:16]);
    arc.push_back(zcdl_pkg::SIG_WORD[15:8]);
    arc.push_back(zcdl_pkg::SIG_WORD[7:0]);
    add_random(int'(zcdl_pkg::OFS_NAME) - int'(zcdl_pkg::SIG_LEN));
    arc.push_back(nl[7:0]);
    arc.push_back(nl[15:8]);
    arc.push_back(xl[7:0]);
    arc.push_back(xl[15:8]);
    arc.push_back(cl[7:0]);
    arc.push_back(cl[15:8]);
    add_random(int'(zcdl_pkg::FIXED_TAIL));
    if (with_body) add_random(nl + xl + cl);
  endtask

  task automatic add_end_record();
    arc.push_back(8'h50);
    arc.push_back(8'h4B);
    arc.push_back(8'h05);
    arc.push_back(8'h06);
  endtask

  task automatic build_random(output logic [31:0] len_v);
    int nrec, roll, k, nl;
    arc.delete();
    add_random($urandom_range(0, 6));
    nrec = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    repeat (nrec) begin
      if ($urandom_range(0, 9) == 0) begin
        add_record(0, 0, 0, 1'b1);
      end else begin
        nl = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
        add_record(nl, $urandom_range(0, 3), $urandom_range(0, 3), 1'b1);
      end
    end
    roll = $urandom_range(0, 99);
    // record whose lengths run past the archive
    if (roll >= 80 && roll < 88)
      add_record($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'b0);
    if ($urandom_range(0, 1) == 1) begin
      add_end_record();
      add_random($urandom_range(0, 18));
    end else begin
      add_random($urandom_range(0, 4));
    end
    if (arc.size() == 0) add_random(1);
    len_v = arc.size();
    if (roll < 50) begin
      // well formed, length matches
    end else if (roll < 60) begin
      if (arc.size() > 1) begin
        k = $urandom_range(1, (arc.size() - 1 < 20) ? arc.size() - 1 : 20);
        repeat (k) void'(arc.pop_back());
      end
    end else if (roll < 70) begin
      len_v = arc.size() - $urandom_range(1, (arc.size() < 30) ? arc.size() : 30);
    end else if (roll < 80) begin
      len_v = arc.size() + $urandom_range(1, 50);
    end else if (roll < 88) begin
      // overrun record already placed
    end else if (roll < 95) begin
      arc[$urandom_range(0, arc.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      len_v = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
    end
  endtask

  initial begin : stimulus
    logic [31:0] len_v;
    int          first_random;
    int          n_arch;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // length zero: nothing is inside the archive
    arc = '{8'hFF, 8'h00};
    run_stream(32'd0, 1'b0);
    // signature found on the final archive byte
    arc = '{8'h50, 8'h4B, 8'h01, 8'h02};
    run_stream(32'd4, 1'b0);
    // huge length, stream ends mid header
    arc = '{8'hAA, 8'h50, 8'h4B, 8'h01, 8'h02, 8'h00, 8'hFF};
    run_stream(32'hFFFF_FFFF, 1'b0);
    // archive length ends inside the header, trailing bytes ignored
    arc = '{8'h50, 8'h4B, 8'h01, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
    run_stream(32'd9, 1'b0);

    // back-pressure: sender never idles while the receiver is parked
    arc.delete();
    add_random(3);
    add_record(40, 2, 2, 1'b1);
    add_record(20, 0, 1, 1'b1);
    add_end_record();
    add_random(18);
    calm_tx = 1'b1;
    flood_req = 1'b1;
    run_stream(arc.size(), 1'b0);
    wait_settled();
    calm_tx = 1'b0;

    first_random = bytes_sent;
    n_arch = 0;
    while (bytes_sent - first_random < RANDOM_BYTES && n_arch < 200) begin
      build_random(len_v);
      calm_tx = (n_arch == 2);
      calm_rx = (n_arch == 2);
      // sender pauses mid archive until the listing has caught up
      run_stream(len_v, n_arch == 1 || $urandom_range(0, 4) == 0);
      n_arch++;
    end

    wait_settled();
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run: %0d archives, %0d bytes in, %0d result words checked, %0d length writes",
             archives_run, bytes_taken, words_checked, length_writes);
    $display("run: names %0d, not found %0d, malformed %0d, finished %0d",
             kind_seen[zcdl_pkg::KIND_NAME], kind_seen[zcdl_pkg::KIND_NOT_FOUND],
             kind_seen[zcdl_pkg::KIND_MALFORMED], kind_seen[zcdl_pkg::KIND_FINISHED]);
    if (mismatches == 0 && listing_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
